>>> rtl/core/twg_pkg.sv
// Package for the tone waveform generator: field widths, waveform codes
// and the quarter-wave sine table function. No dependencies.
package twg_pkg;

    localparam int IDX_W       = 32;
    localparam int RATE_W      = 18;
    localparam int HZ_W        = 17;
    localparam int SAMPLE_W    = 16;
    localparam int WAVE_W      = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int PHASE_BITS_DEF = 12;
    localparam int FULL_AMP    = 32767;
    localparam int RATE_RESET  = 48000;
    localparam int HZ_RESET    = 440;

    typedef enum logic [WAVE_W-1:0] {
        WAVE_SINE   = 2'd0,
        WAVE_COSINE = 2'd1,
        WAVE_SQUARE = 2'd2,
        WAVE_SAW    = 2'd3
    } wave_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WAVEFORM    = 2'd0,
        REG_SAMPLE_RATE = 2'd1,
        REG_TONE_HZ     = 2'd2,
        REG_UNUSED      = 2'd3
    } cfg_reg_t;

    // Quarter-wave entry k, where step is the angle in radians between two
    // neighboring phase codes; rounded half up. Evaluated at
    // elaboration only.
    function automatic logic [SAMPLE_W-1:0] sine_entry(input int k, input real step);
        real ang;
        real v;
        ang = step * real'(k);
        v   = $floor(real'(FULL_AMP) * $sin(ang) + 0.5);
        return SAMPLE_W'(int'(v));
    endfunction

endpackage

>>> rtl/core/tone_waveform_generator_top.sv
// Top level of the tone waveform generator: multiplier, pipelined remainder
// and phase dividers, and the waveform stage. Depends on twg_pkg.
//
// Usage: each item on the s_axis channel carries a sample index; each item on
// the m_axis channel carries one signed 16-bit PCM sample of the configured
// tone. The block forms index*tone_hz, reduces it modulo sample_rate with a
// one-bit-per-stage restoring divider, then derives PHASE_BITS phase bits with
// a second divider of the same kind, and finally maps the phase to sine,
// cosine, square or sawtooth using a quarter-wave constant table.
// From acceptance to the result appearing on m_axis, an item passes through
// the product, the remainder and phase stages, the table read and the output
// register. One item is accepted every cycle while the receiver does not
// stall; every stage advances together.
// When the receiver stalls with a result waiting, the whole pipeline holds and
// s_axis_tready falls, so no item is lost or repeated; items already in flight
// resume when m_axis_tready returns.
// Reset clears all valid bits and returns the registers to sine, 48000 Hz rate
// and a 440 Hz tone. Registers are written through cfg_we/cfg_index/cfg_data
// and must only change while no item is in flight.
module tone_waveform_generator_top
    import twg_pkg::*;
#(
    parameter int PHASE_BITS = PHASE_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [IDX_W-1:0]     s_axis_tdata,   // [31:0] sample_index
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [SAMPLE_W-1:0]  m_axis_tdata,   // [15:0] sample_value
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [RATE_W-1:0]    cfg_data
);

    localparam int DW      = IDX_W + HZ_W;       // product width
    localparam int QSHIFT  = PHASE_BITS - 2;
    localparam int QUARTER = 1 << QSHIFT;
    localparam int HALF    = 1 << (PHASE_BITS - 1);
    localparam int NST     = 1 + DW + PHASE_BITS; // product, remainder and phase stages
    localparam real ANG_STEP = 6.283185307179586 / real'(1 << PHASE_BITS);

    // Configuration registers.
    wave_t             wave_reg;
    logic [RATE_W-1:0] rate_reg;
    logic [HZ_W-1:0]   hz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wave_reg <= WAVE_SINE;
            rate_reg <= RATE_W'(RATE_RESET);
            hz_reg   <= HZ_W'(HZ_RESET);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_WAVEFORM:    wave_reg <= wave_t'(cfg_data[WAVE_W-1:0]);
                REG_SAMPLE_RATE: rate_reg <= cfg_data;
                REG_TONE_HZ:     hz_reg   <= cfg_data[HZ_W-1:0];
                default:         ;
            endcase
        end
    end

    // A zero rate behaves as a rate of one.
    logic [RATE_W:0] rate_eff;
    assign rate_eff = (rate_reg == '0) ? (RATE_W+1)'(1) : {1'b0, rate_reg};

    // Global advance: the pipeline moves unless a result waits unaccepted.
    logic adv;
    assign adv           = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = adv;

    logic vld_reg [NST];

    // Stage 0: product.
    logic [DW-1:0] prod_reg;

    // Remainder stages.
    logic [DW-1:0]     sh_reg [DW];
    logic [RATE_W-1:0] rm_reg [DW];
    logic [DW-1:0]     sh_next [DW];
    logic [RATE_W-1:0] rm_next [DW];

    // Phase stages.
    logic [RATE_W-1:0]     pr_reg [PHASE_BITS];
    logic [PHASE_BITS-1:0] q_reg  [PHASE_BITS];
    logic [RATE_W-1:0]     pr_next [PHASE_BITS];
    logic [PHASE_BITS-1:0] q_next  [PHASE_BITS];

    always_comb
    begin
        logic [RATE_W:0]   t;
        logic [DW-1:0]     sh_in;
        logic [RATE_W-1:0] rm_in;
        logic [PHASE_BITS-1:0] q_in;
        for (int i = 0; i < DW; i++)
        begin
            sh_in = (i == 0) ? prod_reg : sh_reg[(i == 0) ? 0 : i-1];
            rm_in = (i == 0) ? '0 : rm_reg[(i == 0) ? 0 : i-1];
            t = {rm_in, sh_in[DW-1]};
            if (t >= rate_eff)
                t = t - rate_eff;
            rm_next[i] = t[RATE_W-1:0];
            sh_next[i] = {sh_in[DW-2:0], 1'b0};
        end
        for (int j = 0; j < PHASE_BITS; j++)
        begin
            rm_in = (j == 0) ? rm_reg[DW-1] : pr_reg[(j == 0) ? 0 : j-1];
            q_in  = (j == 0) ? '0 : q_reg[(j == 0) ? 0 : j-1];
            t = {rm_in, 1'b0};
            if (t >= rate_eff)
            begin
                t = t - rate_eff;
                q_next[j] = {q_in[PHASE_BITS-2:0], 1'b1};
            end
            else
            begin
                q_next[j] = {q_in[PHASE_BITS-2:0], 1'b0};
            end
            pr_next[j] = t[RATE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NST; i++)
                vld_reg[i] <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg[0] <= s_axis_tvalid;
            for (int i = 1; i < NST; i++)
                vld_reg[i] <= vld_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg <= DW'(s_axis_tdata) * DW'(hz_reg);
            for (int i = 0; i < DW; i++)
            begin
                sh_reg[i] <= sh_next[i];
                rm_reg[i] <= rm_next[i];
            end
            for (int j = 0; j < PHASE_BITS; j++)
            begin
                pr_reg[j] <= pr_next[j];
                q_reg[j]  <= q_next[j];
            end
        end
    end

    // Quarter-wave table, built at elaboration.
    logic [SAMPLE_W-1:0] rom_w [QUARTER+1];
    for (genvar k = 0; k <= QUARTER; k++)
    begin : g_rom
        localparam logic [SAMPLE_W-1:0] ENTRY = sine_entry(k, ANG_STEP);
        assign rom_w[k] = ENTRY;
    end

    // Waveform stage: table address and the square and sawtooth values.
    logic [PHASE_BITS-1:0]  ph;
    logic [PHASE_BITS-1:0]  ph_s;
    logic [QSHIFT:0]        rom_addr;
    logic signed [PHASE_BITS+16:0] saw_d;
    logic signed [SAMPLE_W-1:0] alt_next;
    logic                   sel_sin_next;

    assign ph = q_reg[PHASE_BITS-1];

    always_comb
    begin
        ph_s = (wave_reg == WAVE_COSINE) ? ph + PHASE_BITS'(QUARTER) : ph;
        if (ph_s[QSHIFT])
            rom_addr = (QSHIFT+1)'(QUARTER) - {1'b0, ph_s[QSHIFT-1:0]};
        else
            rom_addr = {1'b0, ph_s[QSHIFT-1:0]};
        saw_d = ($signed((PHASE_BITS+17)'(HALF)) - $signed({17'd0, ph}))
                * $signed((PHASE_BITS+17)'(FULL_AMP));
        sel_sin_next = 1'b0;
        case (wave_reg)
            WAVE_SINE, WAVE_COSINE:
            begin
                sel_sin_next = 1'b1;
                alt_next     = '0;
            end
            WAVE_SQUARE:
            begin
                if (ph == '0 || ph == PHASE_BITS'(HALF))
                    alt_next = '0;
                else if (ph < PHASE_BITS'(HALF))
                    alt_next = SAMPLE_W'(FULL_AMP);
                else
                    alt_next = -SAMPLE_W'(FULL_AMP);
            end
            default: alt_next = SAMPLE_W'(saw_d >>> PHASE_BITS);
        endcase
    end

    // Table read stage: the entry is registered together with its sign and
    // the value of the other waveforms.
    logic                vld_a_reg;
    logic [SAMPLE_W-1:0] rom_q_reg;
    logic                neg_reg;
    logic                sel_sin_reg;
    logic [SAMPLE_W-1:0] alt_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rom_q_reg   <= rom_w[rom_addr];
            neg_reg     <= ph_s[PHASE_BITS-1];
            sel_sin_reg <= sel_sin_next;
            alt_reg     <= alt_next;
        end
    end

    logic signed [SAMPLE_W-1:0] val_next;
    assign val_next = !sel_sin_reg ? $signed(alt_reg)
                    : (neg_reg ? -$signed(rom_q_reg) : $signed(rom_q_reg));

    logic                out_vld_reg;
    logic [SAMPLE_W-1:0] out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_a_reg   <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_a_reg   <= vld_reg[NST-1];
            out_vld_reg <= vld_a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            out_data_reg <= val_next;
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule
